### hdl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// Frustum box cull package
// Shared constants and types of the frustum box cull test.
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

  localparam int NUM_PLANES_DEF  = 6;
  localparam int NUM_CORNERS_DEF = 8;
  localparam int COORD_BITS_DEF  = 32;
  localparam int FIELD_BITS      = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD_PLANE  = 2'd0,
    FUNC_LOAD_CORNER = 2'd1,
    FUNC_TEST_BOX    = 2'd2,
    FUNC_NONE        = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_PLANE  = 2'd1,
    CAUSE_CORNER = 2'd2
  } cause_t;

endpackage

`default_nettype wire

### hdl/fbc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/fbc_dot.sv
// ----------------------------------------------------------------------------
// Plane side unit
// Exact a*x + b*y + c*z + d*2^16 with registered products; gives the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_dot #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic signed [COORD_BITS-1:0] a,
  input  wire logic signed [COORD_BITS-1:0] b,
  input  wire logic signed [COORD_BITS-1:0] c,
  input  wire logic signed [COORD_BITS-1:0] d,
  input  wire logic signed [COORD_BITS-1:0] x,
  input  wire logic signed [COORD_BITS-1:0] y,
  input  wire logic signed [COORD_BITS-1:0] z,
  output logic                              below
);

  localparam int PW = 2 * COORD_BITS;
  localparam int SW = PW + 3;

  logic signed [PW-1:0] px, py, pz;
  logic signed [PW-1:0] pd;
  logic signed [SW-1:0] sum;

  always_ff @(posedge clk) begin
    px <= x * a;
    py <= y * b;
    pz <= z * c;
    pd <= PW'(d) <<< 16;
  end

  assign sum = SW'(px) + SW'(py) + SW'(pz) + SW'(pd);
  assign below = sum[SW-1];

endmodule

`default_nettype wire

### hdl/frustum_box_cull_test.sv
// ----------------------------------------------------------------------------
// Frustum box cull test
// Plane and corner tables in RAM; boxes tested against them one at a time.
// ----------------------------------------------------------------------------
// A load is written into its table when accepted and does not set busy. A
// box test reads one plane per cycle from the plane RAM and checks its eight
// box corners in eight side units (two-stage pipeline), then reads one
// frustum corner per cycle from the corner RAM to build the extent checks; a
// plane cull ends the test early. busy is high throughout; the result
// appears with done for one cycle and cannot be stalled.
`default_nettype none

module frustum_box_cull_test #(
  parameter int NUM_PLANES  = fbc_pkg::NUM_PLANES_DEF,
  parameter int NUM_CORNERS = fbc_pkg::NUM_CORNERS_DEF,
  parameter int COORD_BITS  = fbc_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     func,
  input  wire logic [2:0]                     slot,
  input  wire logic [fbc_pkg::FIELD_BITS-1:0] plane_a,
  input  wire logic [fbc_pkg::FIELD_BITS-1:0] plane_b,
  input  wire logic [fbc_pkg::FIELD_BITS-1:0] plane_c,
  input  wire logic [fbc_pkg::FIELD_BITS-1:0] plane_d,
  input  wire logic [fbc_pkg::FIELD_BITS-1:0] lo_x,
  input  wire logic [fbc_pkg::FIELD_BITS-1:0] lo_y,
  input  wire logic [fbc_pkg::FIELD_BITS-1:0] lo_z,
  input  wire logic [fbc_pkg::FIELD_BITS-1:0] hi_x,
  input  wire logic [fbc_pkg::FIELD_BITS-1:0] hi_y,
  input  wire logic [fbc_pkg::FIELD_BITS-1:0] hi_z,
  output logic                                done,
  output logic                                visible,
  output logic [1:0]                          cull_cause
);

  import fbc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PA = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int CA = $clog2(NUM_CORNERS);
  localparam int PCW = $clog2(NUM_PLANES + 3);
  localparam int CCW = $clog2(NUM_CORNERS + 2);

  typedef enum logic [1:0] {S_IDLE, S_PLANE, S_CORNER} state_t;

  state_t state;
  logic [PCW-1:0] pcnt;
  logic [CCW-1:0] ccnt;
  logic signed [CB-1:0] lo [3];
  logic signed [CB-1:0] hi [3];
  logic [2:0] above, under;

  logic p_we, c_we, in_acc;
  logic [4*CB-1:0] p_rdata;
  logic [3*CB-1:0] c_rdata;
  logic [PA-1:0] p_raddr;
  logic [CA-1:0] c_raddr;
  logic [7:0] below;

  assign in_acc = start && !busy;
  assign p_we = in_acc && func == FUNC_LOAD_PLANE && 32'(slot) < NUM_PLANES;
  assign c_we = in_acc && func == FUNC_LOAD_CORNER;
  assign p_raddr = pcnt < PCW'(NUM_PLANES) ? PA'(pcnt) : '0;
  assign c_raddr = ccnt < CCW'(NUM_CORNERS) ? CA'(ccnt) : '0;

  fbc_ram #(.WIDTH(4 * CB), .DEPTH(NUM_PLANES)) u_plane_ram (
    .clk(clk), .we(p_we), .waddr(PA'(slot)),
    .wdata({plane_d[CB-1:0], plane_c[CB-1:0], plane_b[CB-1:0], plane_a[CB-1:0]}),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  fbc_ram #(.WIDTH(3 * CB), .DEPTH(NUM_CORNERS)) u_corner_ram (
    .clk(clk), .we(c_we), .waddr(CA'(slot)),
    .wdata({lo_z[CB-1:0], lo_y[CB-1:0], lo_x[CB-1:0]}),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  for (genvar k = 0; k < 8; k++) begin : g_dot
    fbc_dot #(.COORD_BITS(CB)) u_dot (
      .clk(clk),
      .a(p_rdata[CB-1:0]), .b(p_rdata[2*CB-1:CB]),
      .c(p_rdata[3*CB-1:2*CB]), .d(p_rdata[4*CB-1:3*CB]),
      .x(((k & 1) != 0) ? hi[0] : lo[0]), .y(((k & 2) != 0) ? hi[1] : lo[1]),
      .z(((k & 4) != 0) ? hi[2] : lo[2]),
      .below(below[k])
    );
  end

  logic [2:0] gt, lt;
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      gt[ax] = $signed(c_rdata[ax*CB +: CB]) > hi[ax];
      lt[ax] = $signed(c_rdata[ax*CB +: CB]) < lo[ax];
    end
  end

  // Plane read at pcnt; RAM data and side-unit products registered in turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      pcnt <= '0;
      ccnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (in_acc && func == FUNC_TEST_BOX) begin
            lo[0] <= CB'(lo_x); lo[1] <= CB'(lo_y); lo[2] <= CB'(lo_z);
            hi[0] <= CB'(hi_x); hi[1] <= CB'(hi_y); hi[2] <= CB'(hi_z);
            state <= S_PLANE;
            busy <= 1'b1;
            pcnt <= '0;
          end
        end
        S_PLANE: begin
          pcnt <= pcnt + 1'b1;
          if (pcnt >= PCW'(2) && below == 8'hFF) begin
            visible <= 1'b0;
            cull_cause <= CAUSE_PLANE;
            done <= 1'b1;
            busy <= 1'b0;
            state <= S_IDLE;
          end else begin
            done <= 1'b0;
            if (pcnt == PCW'(NUM_PLANES + 1)) begin
              state <= S_CORNER;
              ccnt <= '0;
              above <= '1;
              under <= '1;
            end
          end
        end
        S_CORNER: begin
          ccnt <= ccnt + 1'b1;
          if (ccnt >= CCW'(1)) begin
            above <= above & gt;
            under <= under & lt;
          end
          if (ccnt == CCW'(NUM_CORNERS + 1)) begin
            if ((above | under) != 3'b000) begin
              visible <= 1'b0;
              cull_cause <= CAUSE_CORNER;
            end else begin
              visible <= 1'b1;
              cull_cause <= CAUSE_NONE;
            end
            done <= 1'b1;
            busy <= 1'b0;
            state <= S_IDLE;
          end else begin
            done <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          done <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/frustum_box_cull_test_tb.sv
// ----------------------------------------------------------------------------
// Frustum box cull testbench
// Loads frustum planes and corners, tests boxes against them and checks every
// result against a bit-exact predictor with its own copy of both tables.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_cull_test_tb;
  import fbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_RANDOM     = 850;

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  typedef struct {
    func_t              func;
    logic [2:0]         slot;
    logic signed [31:0] pa, pb, pc, pd;
    logic signed [31:0] lx, ly, lz, hx, hy, hz;
  } cull_item_t;

  typedef struct {
    logic   vis;
    cause_t cause;
  } cull_verdict_t;

  typedef struct {
    cull_item_t    item;
    logic          typed;
    cull_verdict_t verdict;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  func = FUNC_NONE;
  logic [2:0]  slot = '0;
  logic [31:0] plane_a = '0, plane_b = '0, plane_c = '0, plane_d = '0;
  logic [31:0] lo_x = '0, lo_y = '0, lo_z = '0, hi_x = '0, hi_y = '0, hi_z = '0;
  logic        busy, done, visible;
  logic [1:0]  cull_cause;

  logic signed [31:0] plane_tab [0:NUM_PLANES_DEF-1][0:3];
  logic signed [31:0] corner_tab [0:NUM_CORNERS_DEF-1][0:2];
  cull_verdict_t      pending_verdicts [$];
  stim_row_t          stim_table [$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 n_tests = 0, n_plane = 0, n_corner = 0, n_vis = 0, n_loads = 0;

  frustum_box_cull_test i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .slot(slot),
    .plane_a(plane_a), .plane_b(plane_b), .plane_c(plane_c), .plane_d(plane_d),
    .lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z), .hi_x(hi_x), .hi_y(hi_y), .hi_z(hi_z),
    .done(done), .visible(visible), .cull_cause(cull_cause)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic point_below(int p, logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [31:0] z);
    logic signed [71:0] acc;
    acc = 72'(plane_tab[p][0]) * 72'(x) + 72'(plane_tab[p][1]) * 72'(y)
        + 72'(plane_tab[p][2]) * 72'(z) + (72'(plane_tab[p][3]) <<< 16);
    return acc < 0;
  endfunction

  function automatic cull_verdict_t cull_box(cull_item_t it);
    logic signed [31:0] lo [0:2];
    logic signed [31:0] hi [0:2];
    int                 n_below, n_above, n_under;
    cull_verdict_t      v;
    lo = '{it.lx, it.ly, it.lz};
    hi = '{it.hx, it.hy, it.hz};
    for (int p = 0; p < NUM_PLANES_DEF; p++) begin
      n_below = 0;
      for (int k = 0; k < 8; k++) begin
        if (point_below(p, k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1], k[2] ? hi[2] : lo[2]))
          n_below++;
      end
      if (n_below == 8) begin
        v.vis = 1'b0;
        v.cause = CAUSE_PLANE;
        return v;
      end
    end
    for (int ax = 0; ax < 3; ax++) begin
      n_above = 0;
      n_under = 0;
      for (int k = 0; k < NUM_CORNERS_DEF; k++) begin
        if (corner_tab[k][ax] > hi[ax]) n_above++;
        if (corner_tab[k][ax] < lo[ax]) n_under++;
      end
      if (n_above == NUM_CORNERS_DEF || n_under == NUM_CORNERS_DEF) begin
        v.vis = 1'b0;
        v.cause = CAUSE_CORNER;
        return v;
      end
    end
    v.vis = 1'b1;
    v.cause = CAUSE_NONE;
    return v;
  endfunction

  // Updates the tables for a load, or returns the verdict of a box test.
  task automatic apply_item(cull_item_t it, output logic has_verdict, output cull_verdict_t v);
    has_verdict = 1'b0;
    v = '{1'b0, CAUSE_NONE};
    case (it.func)
      FUNC_LOAD_PLANE: begin
        n_loads++;
        if (it.slot < NUM_PLANES_DEF) plane_tab[it.slot] = '{it.pa, it.pb, it.pc, it.pd};
      end
      FUNC_LOAD_CORNER: begin
        n_loads++;
        corner_tab[it.slot] = '{it.lx, it.ly, it.lz};
      end
      FUNC_TEST_BOX: begin
        has_verdict = 1'b1;
        v = cull_box(it);
        n_tests++;
        case (v.cause)
          CAUSE_PLANE:  n_plane++;
          CAUSE_CORNER: n_corner++;
          default:      n_vis++;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic issue_item(cull_item_t it, logic typed, cull_verdict_t typed_v);
    logic          has_v;
    cull_verdict_t v;
    start   <= 1'b1;
    func    <= it.func;
    slot    <= it.slot;
    plane_a <= it.pa;
    plane_b <= it.pb;
    plane_c <= it.pc;
    plane_d <= it.pd;
    lo_x    <= it.lx;
    lo_y    <= it.ly;
    lo_z    <= it.lz;
    hi_x    <= it.hx;
    hi_y    <= it.hy;
    hi_z    <= it.hz;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_item(it, has_v, v);
    if (has_v) begin
      if (typed && (v.vis !== typed_v.vis || v.cause !== typed_v.cause)) begin
        $error("directed row disagrees with predictor: typed %0d/%0d, predicted %0d/%0d",
               typed_v.vis, typed_v.cause, v.vis, v.cause);
        errors++;
      end
      pending_verdicts.push_back(typed ? typed_v : v);
    end
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 9) < 5) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic cull_item_t mk(func_t f, int s,
                                    logic signed [31:0] pa, logic signed [31:0] pb,
                                    logic signed [31:0] pc, logic signed [31:0] pd,
                                    logic signed [31:0] lx, logic signed [31:0] ly,
                                    logic signed [31:0] lz, logic signed [31:0] hx,
                                    logic signed [31:0] hy, logic signed [31:0] hz);
    cull_item_t it;
    it = '{f, 3'(s), pa, pb, pc, pd, lx, ly, lz, hx, hy, hz};
    return it;
  endfunction

  task automatic add_row(cull_item_t it, logic typed = 1'b0, logic vis = 1'b0,
                         cause_t cause = CAUSE_NONE);
    stim_row_t r;
    r.item = it;
    r.typed = typed;
    r.verdict = '{vis, cause};
    stim_table.push_back(r);
  endtask

  function automatic logic signed [31:0] rand_value(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return $signed($urandom_range(0, 32'h00A0_0000)) - 32'sh0050_0000;
      default: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  function automatic cull_item_t rand_item();
    cull_item_t         it;
    int                 pick, mode;
    logic signed [31:0] t;
    pick = $urandom_range(0, 99);
    mode = ($urandom_range(0, 9) < 2) ? 0 : ($urandom_range(0, 19) == 0) ? 3 : 1;
    it.func = (pick < 15) ? FUNC_LOAD_PLANE : (pick < 25) ? FUNC_LOAD_CORNER :
              (pick < 29) ? FUNC_NONE : FUNC_TEST_BOX;
    it.slot = 3'($urandom_range(0, 7));
    it.pa = rand_value(mode);
    it.pb = rand_value(mode);
    it.pc = rand_value(mode);
    it.pd = rand_value(mode);
    if (it.func == FUNC_LOAD_CORNER) mode = (mode == 1) ? 2 : mode;
    it.lx = rand_value(mode);
    it.ly = rand_value(mode);
    it.lz = rand_value(mode);
    it.hx = rand_value(mode);
    it.hy = rand_value(mode);
    it.hz = rand_value(mode);
    if ($urandom_range(0, 9) != 0) begin
      if (it.lx > it.hx) begin t = it.lx; it.lx = it.hx; it.hx = t; end
      if (it.ly > it.hy) begin t = it.ly; it.ly = it.hy; it.hy = t; end
      if (it.lz > it.hz) begin t = it.lz; it.lz = it.hz; it.hz = t; end
    end
    return it;
  endfunction

  always @(posedge clk) begin
    cull_verdict_t v;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no item outstanding: visible %0d cull_cause %0d",
               visible, cull_cause);
        errors++;
      end else begin
        v = pending_verdicts.pop_front();
        if (visible !== v.vis) begin
          $error("visible: expected %0d, actual %0d", v.vis, visible);
          errors++;
        end
        if (cull_cause !== v.cause) begin
          $error("cull_cause: expected %0d, actual %0d", v.cause, cull_cause);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_verdicts.size());
      $display("frustum_box_cull_test_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int         tail;
    cull_item_t it;

    for (int p = 0; p < NUM_PLANES_DEF; p++)
      add_row(mk(FUNC_LOAD_PLANE, p, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < NUM_CORNERS_DEF; k++)
      add_row(mk(FUNC_LOAD_CORNER, k, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_TEST_BOX, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE),
            1'b1, 1'b1, CAUSE_NONE);
    add_row(mk(FUNC_TEST_BOX, 0, 0, 0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE),
            1'b1, 1'b0, CAUSE_CORNER);
    add_row(mk(FUNC_TEST_BOX, 0, 0, 0, 0, 0, MINV, MINV, MINV, -ONE, -ONE, -ONE),
            1'b1, 1'b0, CAUSE_CORNER);
    add_row(mk(FUNC_LOAD_PLANE, 0, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_TEST_BOX, 0, 0, 0, 0, 0, -2*ONE, -ONE, -ONE, -ONE, ONE, ONE),
            1'b1, 1'b0, CAUSE_PLANE);
    add_row(mk(FUNC_TEST_BOX, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, 0, ONE, ONE),
            1'b1, 1'b1, CAUSE_NONE);
    add_row(mk(FUNC_TEST_BOX, 0, 0, 0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE));
    add_row(mk(FUNC_LOAD_PLANE, 6, -ONE, 0, 0, MINV, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_LOAD_PLANE, 7, -ONE, 0, 0, MINV, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_NONE, 7, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    add_row(mk(FUNC_TEST_BOX, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, 0, ONE, ONE),
            1'b1, 1'b1, CAUSE_NONE);
    add_row(mk(FUNC_LOAD_PLANE, 5, MINV, MINV, MINV, MINV, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_TEST_BOX, 0, 0, 0, 0, 0, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    add_row(mk(FUNC_LOAD_PLANE, 5, MAXV, MAXV, MAXV, MAXV, 0, 0, 0, 0, 0, 0));
    add_row(mk(FUNC_TEST_BOX, 0, 0, 0, 0, 0, MINV, MINV, MINV, MAXV, MAXV, MAXV));
    add_row(mk(FUNC_LOAD_CORNER, 3, 0, 0, 0, 0, MAXV, MINV, MAXV, 0, 0, 0));
    add_row(mk(FUNC_TEST_BOX, 0, 0, 0, 0, 0, MINV, MINV, MINV, MAXV, MAXV, MAXV));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_table[i]) begin
      issue_item(stim_table[i].item, stim_table[i].typed, stim_table[i].verdict);
      idle_gap();
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      it = rand_item();
      issue_item(it, 1'b0, '{1'b0, CAUSE_NONE});
      idle_gap();
    end
    start <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < 40) begin
      @(posedge clk);
      tail++;
    end

    $display("Tested %0d boxes after %0d table loads:", n_tests, n_loads);
    $display("  %0d visible, %0d plane culls, %0d corner culls.",
             n_vis, n_plane, n_corner);
    if (errors == 0) begin
      $display("frustum_box_cull_test_tb OK");
    end else begin
      $display("frustum_box_cull_test_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

### frustum_box_cull_test.f
hdl/fbc_pkg.sv
hdl/fbc_ram.sv
hdl/fbc_dot.sv
hdl/frustum_box_cull_test.sv
tb/frustum_box_cull_test_tb.sv
